// ----- rtl/rrte_pkg.sv -----
`timescale 1ns / 1ps
package rrte_pkg;

    localparam logic [1:0] ACT_RECEIVE = 2'd0;
    localparam logic [1:0] ACT_INSTALL = 2'd1;
    localparam logic [1:0] ACT_READ    = 2'd2;

    localparam logic [2:0] ST_SKIPPED   = 3'd0;
    localparam logic [2:0] ST_INSERTED  = 3'd1;
    localparam logic [2:0] ST_REFRESHED = 3'd2;
    localparam logic [2:0] ST_REPLACED  = 3'd3;
    localparam logic [2:0] ST_UNCHANGED = 3'd4;
    localparam logic [2:0] ST_FULL      = 3'd5;
    localparam logic [2:0] ST_READ      = 3'd6;
    localparam logic [2:0] ST_EMPTY     = 3'd7;

    localparam logic [7:0] NEXT_HOP_MARK = 8'hff;
    localparam logic [4:0] METRIC_INF    = 5'd16;

    // One route as it is held in a cell.
    typedef struct packed {
        logic [63:0] prefix_high;
        logic [63:0] prefix_low;
        logic [7:0]  length;
        logic [3:0]  iface;
        logic [63:0] hop_high;
        logic [63:0] hop_low;
        logic [15:0] tag;
        logic [4:0]  metric;
    } t_route;

    // Command from the controller to the write logic that feeds the tail cell.
    typedef struct packed {
        logic        write;     // write full route
        logic        refresh;   // update metric and iface only
        t_route      route;
    } t_cell_cmd;

endpackage

// ----- rtl/rrte_if.sv -----
`timescale 1ns / 1ps
interface rrte_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [63:0] prefix_high;
    logic [63:0] prefix_low;
    logic [7:0]  prefix_length;
    logic [15:0] tag;
    logic [7:0]  metric_in;
    logic [63:0] peer_high;
    logic [63:0] peer_low;
    logic [1:0]  iface;
    logic [5:0]  slot;
    modport source (output valid, action, prefix_high, prefix_low, prefix_length, tag,
                    metric_in, peer_high, peer_low, iface, slot, input ready);
    modport sink (input valid, action, prefix_high, prefix_low, prefix_length, tag,
                  metric_in, peer_high, peer_low, iface, slot, output ready);
endinterface

interface rrte_rsp_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [63:0] out_prefix_high;
    logic [63:0] out_prefix_low;
    logic [7:0]  out_length;
    logic [15:0] out_tag;
    logic [4:0]  out_metric;
    modport source (output valid, status, out_prefix_high, out_prefix_low, out_length,
                    out_tag, out_metric, input ready);
    modport sink (input valid, status, out_prefix_high, out_prefix_low, out_length,
                  out_tag, out_metric, output ready);
endinterface

// ----- rtl/rrte_cell.sv -----
`timescale 1ns / 1ps
// One table slot. The route rotates through the ring of cells, so the
// controller sees one entry per cycle at the head of the chain while i_shift is high.
module rrte_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_shift,
    input  logic               i_valid,
    input  rrte_pkg::t_route   i_route,
    output logic               o_valid,
    output rrte_pkg::t_route   o_route
);
    logic             r_valid;
    rrte_pkg::t_route r_route;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_shift) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_route <= i_route;
        end
    end

    assign o_valid = r_valid;
    assign o_route = r_route;
endmodule

// ----- rtl/ripng_route_table_engine.sv -----
`timescale 1ns / 1ps
// RIPng route table engine. The table is a ring of TABLE_DEPTH cells that
// rotates by one entry per cycle during the search and apply passes; the
// controller compares the entry at the head of the ring with the request
// and may rewrite it as it passes. Each item takes one full rotation to
// search all entries and a second to apply the write to the chosen slot
// (the ring returns to its home position after each pass), then the result
// hand-off; no new request is taken until the result is taken. Reads take
// the same two passes. One result item is produced for each input item,
// held in an output register until taken. No clearing pass is needed after
// reset; valid bits are cleared at once.
module ripng_route_table_engine #(
    parameter int TABLE_DEPTH = 64,
    parameter int IFACE_COUNT = 4
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    rrte_req_if.sink   i_req,
    rrte_rsp_if.source o_rsp
);
    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SEARCH = 4'b0010,
        S_APPLY  = 4'b0100,
        S_OUT    = 4'b1000
    } t_state;

    t_state r_state, n_state;
    logic [CW-1:0] r_cnt;

    // Request hold register.
    logic [1:0]  r_action;
    rrte_pkg::t_route r_req;
    logic [7:0]  r_min;
    logic [5:0]  r_slot;
    logic        r_ifc_ok;

    // Search results.
    logic          r_match_hit, r_free_hit;
    logic [IW-1:0] r_match_idx, r_free_idx;
    logic          r_hop_same;
    logic [4:0]    r_match_metric;
    logic [2:0]    r_status;
    rrte_pkg::t_route r_rd;

    // Decision drawn from the search results, stable for the whole apply pass.
    logic          w_do_write, w_do_refresh;
    logic [IW-1:0] w_tgt_idx;

    // Ring of cells. Cell 0 is the head; data moves from cell k+1 to cell k
    // and the head wraps back to the tail through the write logic.
    logic             w_valid [TABLE_DEPTH];
    rrte_pkg::t_route w_route [TABLE_DEPTH];
    logic             w_in_valid [TABLE_DEPTH];
    rrte_pkg::t_route w_in_route [TABLE_DEPTH];
    logic             w_shift;
    logic             w_tail_valid;
    rrte_pkg::t_route w_tail_route;
    rrte_pkg::t_cell_cmd w_cmd;
    logic [IW-1:0]    w_pos;

    genvar g;
    generate
        for (g = 0; g < TABLE_DEPTH; g++) begin : g_cell
            rrte_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (w_shift),
                .i_valid (w_in_valid[g]),
                .i_route (w_in_route[g]),
                .o_valid (w_valid[g]),
                .o_route (w_route[g])
            );
            if (g < TABLE_DEPTH - 1) begin : g_link
                assign w_in_valid[g] = w_valid[g+1];
                assign w_in_route[g] = w_route[g+1];
            end else begin : g_wrap
                assign w_in_valid[g] = w_tail_valid;
                assign w_in_route[g] = w_tail_route;
            end
        end
    endgenerate

    assign w_shift = (r_state == S_SEARCH) || (r_state == S_APPLY);
    assign w_pos   = r_cnt[IW-1:0];

    // Head entry matches the request key.
    logic w_key_eq;
    assign w_key_eq = w_valid[0] && w_route[0].prefix_high == r_req.prefix_high
                   && w_route[0].prefix_low == r_req.prefix_low
                   && w_route[0].length == r_req.length;

    // Head entry as an advertisement would show it, with poisoned reverse.
    rrte_pkg::t_route w_rd_head;
    always_comb begin
        w_rd_head = w_route[0];
        if (w_route[0].iface == r_req.iface) begin
            w_rd_head.metric = rrte_pkg::METRIC_INF;
        end
    end

    always_comb begin
        w_cmd.write   = 1'b0;
        w_cmd.refresh = 1'b0;
        w_cmd.route   = r_req;
        if (r_state == S_APPLY && w_pos == w_tgt_idx) begin
            w_cmd.write   = w_do_write;
            w_cmd.refresh = w_do_refresh;
        end
        w_tail_valid = w_valid[0] || w_cmd.write;
        w_tail_route = w_route[0];
        if (w_cmd.write) begin
            w_tail_route = w_cmd.route;
        end else if (w_cmd.refresh) begin
            w_tail_route.metric = w_cmd.route.metric;
            w_tail_route.iface  = w_cmd.route.iface;
        end
    end

    // Received metric plus one, saturated at infinity.
    logic [4:0] w_rx_m, w_in_m;
    assign w_rx_m = (r_min >= 8'd15) ? rrte_pkg::METRIC_INF : 5'(r_min + 8'd1);
    assign w_in_m = (r_min > 8'd16) ? rrte_pkg::METRIC_INF : r_min[4:0];

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:   if (i_req.valid) n_state = S_SEARCH;
            S_SEARCH: if (r_cnt == CW'(TABLE_DEPTH - 1)) n_state = S_APPLY;
            S_APPLY:  if (r_cnt == CW'(TABLE_DEPTH - 1)) n_state = S_OUT;
            S_OUT:    if (o_rsp.ready) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    assign i_req.ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_SEARCH || r_state == S_APPLY) begin
                r_cnt <= (r_cnt == CW'(TABLE_DEPTH - 1)) ? '0 : r_cnt + 1'b1;
            end else begin
                r_cnt <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_action            <= i_req.action;
                r_req.prefix_high   <= i_req.prefix_high;
                r_req.prefix_low    <= i_req.prefix_low;
                r_req.length        <= i_req.prefix_length;
                r_req.iface         <= 4'(i_req.iface);
                r_req.hop_high      <= i_req.peer_high;
                r_req.hop_low       <= i_req.peer_low;
                r_req.tag           <= i_req.tag;
                r_req.metric        <= '0;
                r_min               <= i_req.metric_in;
                r_slot              <= i_req.slot;
                r_ifc_ok            <= (32'(i_req.iface) < IFACE_COUNT);
                r_match_hit         <= 1'b0;
                r_free_hit          <= 1'b0;
                r_match_idx         <= '0;
                r_free_idx          <= '0;
                r_hop_same          <= 1'b0;
                r_match_metric      <= '0;
                r_status            <= rrte_pkg::ST_EMPTY;
                r_rd                <= '0;
            end
            S_SEARCH: begin
                if (w_key_eq && !r_match_hit) begin
                    r_match_hit    <= 1'b1;
                    r_match_idx    <= w_pos;
                    r_hop_same     <= w_route[0].hop_high == r_req.hop_high
                                   && w_route[0].hop_low == r_req.hop_low;
                    r_match_metric <= w_route[0].metric;
                end
                if (!w_valid[0] && !r_free_hit) begin
                    r_free_hit <= 1'b1;
                    r_free_idx <= w_pos;
                end
                if (32'(r_slot) == 32'(w_pos) && w_valid[0]) begin
                    r_status <= rrte_pkg::ST_READ;
                    r_rd     <= w_rd_head;
                end
                if (r_cnt == CW'(TABLE_DEPTH - 1)) begin
                    r_req.metric <= (r_action == rrte_pkg::ACT_RECEIVE) ? w_rx_m : w_in_m;
                end
            end
            default: ;
        endcase
    end

    // Decision from the search pass. Every input to it is settled once the
    // search pass ends, so it holds for every slot of the apply pass,
    // slot 0 included.
    always_comb begin
        w_do_write   = 1'b0;
        w_do_refresh = 1'b0;
        w_tgt_idx    = r_match_hit ? r_match_idx : r_free_idx;
        case (r_action)
            rrte_pkg::ACT_RECEIVE: begin
                if (r_ifc_ok && r_min != rrte_pkg::NEXT_HOP_MARK) begin
                    if (!r_match_hit) begin
                        w_do_write = r_free_hit && r_req.metric < rrte_pkg::METRIC_INF;
                    end else if (r_hop_same) begin
                        w_do_refresh = 1'b1;
                    end else begin
                        w_do_write = r_req.metric < r_match_metric;
                    end
                end
            end
            rrte_pkg::ACT_INSTALL: begin
                w_do_write = r_ifc_ok && (r_match_hit || r_free_hit);
            end
            default: ;
        endcase
    end

    logic [2:0] w_status;
    always_comb begin
        w_status = rrte_pkg::ST_SKIPPED;
        case (r_action)
            rrte_pkg::ACT_RECEIVE: begin
                if (r_ifc_ok && r_min != rrte_pkg::NEXT_HOP_MARK) begin
                    if (!r_match_hit) begin
                        if (r_req.metric >= rrte_pkg::METRIC_INF)
                            w_status = rrte_pkg::ST_UNCHANGED;
                        else if (r_free_hit) w_status = rrte_pkg::ST_INSERTED;
                        else w_status = rrte_pkg::ST_FULL;
                    end else if (r_hop_same) begin
                        w_status = rrte_pkg::ST_REFRESHED;
                    end else if (r_req.metric < r_match_metric) begin
                        w_status = rrte_pkg::ST_REPLACED;
                    end else begin
                        w_status = rrte_pkg::ST_UNCHANGED;
                    end
                end
            end
            rrte_pkg::ACT_INSTALL: begin
                if (r_ifc_ok) begin
                    if (r_match_hit) w_status = rrte_pkg::ST_REPLACED;
                    else if (r_free_hit) w_status = rrte_pkg::ST_INSERTED;
                    else w_status = rrte_pkg::ST_FULL;
                end
            end
            rrte_pkg::ACT_READ: w_status = r_status;
            default: w_status = rrte_pkg::ST_SKIPPED;
        endcase
    end

    assign o_rsp.valid = (r_state == S_OUT);
    assign o_rsp.status = w_status;
    assign o_rsp.out_prefix_high = (w_status == rrte_pkg::ST_READ) ? r_rd.prefix_high : '0;
    assign o_rsp.out_prefix_low  = (w_status == rrte_pkg::ST_READ) ? r_rd.prefix_low : '0;
    assign o_rsp.out_length      = (w_status == rrte_pkg::ST_READ) ? r_rd.length : '0;
    assign o_rsp.out_tag         = (w_status == rrte_pkg::ST_READ) ? r_rd.tag : '0;
    assign o_rsp.out_metric      = (w_status == rrte_pkg::ST_READ) ? r_rd.metric : '0;

`ifndef SYNTHESIS
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.ready |-> !o_rsp.valid) else $error("ready while result pending");
    a_write_apply: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.write || w_cmd.refresh) |-> (r_state == S_APPLY))
        else $error("cell write outside apply pass");
    a_one_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_do_write && w_do_refresh)) else $error("write and refresh together");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && !o_rsp.ready) |=> o_rsp.valid) else $error("result dropped");
`endif
endmodule
